>>> rtl/core/fptr_pkg.sv
// Shared types, constants and helper functions for the forked page-table registry.
// Depends on nothing; fptr_ctrl and the top level import it.
package fptr_pkg;

  localparam int UPPER_DEPTH  = 64;
  localparam int MIDDLE_DEPTH = 64;
  localparam int LOWER_DEPTH  = 64;
  localparam int FRAME_BITS   = 40;

  localparam int MAX_DEPTH_UM = (UPPER_DEPTH > MIDDLE_DEPTH) ? UPPER_DEPTH : MIDDLE_DEPTH;
  localparam int MAX_DEPTH    = (MAX_DEPTH_UM > LOWER_DEPTH) ? MAX_DEPTH_UM : LOWER_DEPTH;
  localparam int TOTAL_DEPTH  = UPPER_DEPTH + MIDDLE_DEPTH + LOWER_DEPTH;
  localparam int UPPER_BASE   = 0;
  localparam int MIDDLE_BASE  = UPPER_DEPTH;
  localparam int LOWER_BASE   = UPPER_DEPTH + MIDDLE_DEPTH;

  localparam int ADDR_W     = (TOTAL_DEPTH > 1) ? $clog2(TOTAL_DEPTH) : 1;
  localparam int CNT_W      = $clog2(MAX_DEPTH + 1);
  localparam int SLOT_W     = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int IDX_W      = 9;
  localparam int KEY_W      = 3 * IDX_W;
  localparam int OUT_FRAME_W = 40;
  localparam int OUT_SLOT_W = 6;
  localparam int PAIR_W     = 2 * FRAME_BITS;

  localparam logic       ACT_LOOKUP   = 1'b0;
  localparam logic       ACT_REGISTER = 1'b1;

  localparam logic [1:0] LEVEL_UPPER  = 2'd0;
  localparam logic [1:0] LEVEL_MIDDLE = 2'd1;
  localparam logic [1:0] LEVEL_LOWER  = 2'd2;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_SCAN,
    FSM_DONE
  } fsm_e;

  typedef struct packed {
    logic                   action;
    logic [1:0]             level;
    logic [IDX_W-1:0]       top_index;
    logic [IDX_W-1:0]       second_index;
    logic [IDX_W-1:0]       third_index;
    logic [OUT_FRAME_W-1:0] new_forked_frame;
    logic [OUT_FRAME_W-1:0] new_original_frame;
  } in_word_t;

  typedef struct packed {
    logic [1:0]             status;
    logic [OUT_SLOT_W-1:0]  slot;
    logic [OUT_FRAME_W-1:0] forked_frame;
    logic [OUT_FRAME_W-1:0] original_frame;
  } out_word_t;

  function automatic logic level_ok(input logic [1:0] level);
    return (level == LEVEL_UPPER) || (level == LEVEL_MIDDLE) || (level == LEVEL_LOWER);
  endfunction

  function automatic logic [CNT_W-1:0] depth_of(input logic [1:0] level);
    logic [CNT_W-1:0] d;
    case (level)
      LEVEL_UPPER:  d = CNT_W'(UPPER_DEPTH);
      LEVEL_MIDDLE: d = CNT_W'(MIDDLE_DEPTH);
      LEVEL_LOWER:  d = CNT_W'(LOWER_DEPTH);
      default:      d = '0;
    endcase
    return d;
  endfunction

  function automatic logic [ADDR_W-1:0] base_of(input logic [1:0] level);
    logic [ADDR_W-1:0] b;
    case (level)
      LEVEL_MIDDLE: b = ADDR_W'(MIDDLE_BASE);
      LEVEL_LOWER:  b = ADDR_W'(LOWER_BASE);
      default:      b = ADDR_W'(UPPER_BASE);
    endcase
    return b;
  endfunction

  function automatic logic [KEY_W-1:0] key_of(input in_word_t w);
    logic [KEY_W-1:0] k;
    case (w.level)
      LEVEL_LOWER:  k = {w.top_index, w.second_index, w.third_index};
      LEVEL_MIDDLE: k = {{IDX_W{1'b0}}, w.top_index, w.second_index};
      default:      k = {{(2 * IDX_W){1'b0}}, w.top_index};
    endcase
    return k;
  endfunction

  function automatic logic [FRAME_BITS-1:0] frame_in(input logic [OUT_FRAME_W-1:0] f);
    logic [FRAME_BITS+OUT_FRAME_W-1:0] t;
    t = {{FRAME_BITS{1'b0}}, f};
    return t[FRAME_BITS-1:0];
  endfunction

  function automatic logic [OUT_FRAME_W-1:0] frame_out(input logic [FRAME_BITS-1:0] f);
    logic [FRAME_BITS+OUT_FRAME_W-1:0] t;
    t = {{OUT_FRAME_W{1'b0}}, f};
    return t[OUT_FRAME_W-1:0];
  endfunction

  function automatic logic [OUT_SLOT_W-1:0] slot_out(input logic [SLOT_W-1:0] s);
    logic [SLOT_W+OUT_SLOT_W-1:0] t;
    t = {{OUT_SLOT_W{1'b0}}, s};
    return t[OUT_SLOT_W-1:0];
  endfunction

endpackage

>>> rtl/core/fptr_mem.sv
// Generic simple dual-port RAM with one write port and one registered read port.
// Holds no reset; used for the key store and the frame store of the registry.
module fptr_mem #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                                         clk_i,
  input  logic                                         wr_en_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]                             wr_data_i,
  input  logic                                         rd_en_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]                             rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

>>> rtl/core/fptr_ctrl.sv
// Sequencer of the registry: appends entries, scans a table one slot per cycle,
// and holds the result word. Depends on fptr_pkg and drives the two fptr_mem stores.
module fptr_ctrl import fptr_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  in_word_t          in_word_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output out_word_t         out_word_o,
  output logic              wr_en_o,
  output logic [ADDR_W-1:0] wr_addr_o,
  output logic [KEY_W-1:0]  wr_key_o,
  output logic [PAIR_W-1:0] wr_pair_o,
  output logic              rd_en_o,
  output logic [ADDR_W-1:0] rd_addr_o,
  input  logic [KEY_W-1:0]  rd_key_i,
  input  logic [PAIR_W-1:0] rd_pair_i
);

  fsm_e              state_q, state_d;
  logic [CNT_W-1:0]  cnt_q [3];
  logic [CNT_W-1:0]  cnt_d [3];
  logic [KEY_W-1:0]  key_q, key_d;
  logic [1:0]        lvl_q, lvl_d;
  logic [CNT_W-1:0]  idx_q, idx_d;
  logic [CNT_W-1:0]  lim_q, lim_d;
  logic              pend_q, pend_d;
  logic [SLOT_W-1:0] cmp_q, cmp_d;
  out_word_t         res_q, res_d;
  out_word_t         out_q, out_d;
  logic              out_valid_q, out_valid_d;

  logic              accept;
  logic              ok;
  logic [CNT_W-1:0]  cnt_sel;
  logic              hit;
  logic              last;
  logic              load;
  logic [FRAME_BITS-1:0] new_fork;
  logic [FRAME_BITS-1:0] new_orig;

  assign accept   = (state_q == FSM_IDLE) && in_valid_i;
  assign ok       = level_ok(in_word_i.level);
  assign new_fork = frame_in(in_word_i.new_forked_frame);
  assign new_orig = frame_in(in_word_i.new_original_frame);
  assign hit      = pend_q && (rd_key_i == key_q);
  assign last     = pend_q && ((CNT_W'(cmp_q) + CNT_W'(1)) == lim_q);
  assign load     = (state_q == FSM_DONE) && (!out_valid_q || !out_stall_i);

  always_comb begin
    case (in_word_i.level)
      LEVEL_UPPER:  cnt_sel = cnt_q[0];
      LEVEL_MIDDLE: cnt_sel = cnt_q[1];
      LEVEL_LOWER:  cnt_sel = cnt_q[2];
      default:      cnt_sel = '0;
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      FSM_IDLE: begin
        if (in_valid_i) begin
          if ((in_word_i.action == ACT_LOOKUP) && ok && (cnt_sel != '0)) begin
            state_d = FSM_SCAN;
          end else begin
            state_d = FSM_DONE;
          end
        end
      end
      FSM_SCAN: begin
        if (hit || last) begin
          state_d = FSM_DONE;
        end
      end
      FSM_DONE: begin
        if (load) begin
          state_d = FSM_IDLE;
        end
      end
      default: state_d = FSM_IDLE;
    endcase
  end

  always_comb begin
    cnt_d       = cnt_q;
    key_d       = key_q;
    lvl_d       = lvl_q;
    idx_d       = idx_q;
    lim_d       = lim_q;
    pend_d      = 1'b0;
    cmp_d       = cmp_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    wr_en_o     = 1'b0;
    wr_addr_o   = base_of(in_word_i.level) + ADDR_W'(cnt_sel);
    wr_key_o    = key_of(in_word_i);
    wr_pair_o   = {new_fork, new_orig};
    rd_en_o     = 1'b0;
    rd_addr_o   = base_of(lvl_q) + ADDR_W'(idx_q);

    case (state_q)
      FSM_IDLE: begin
        if (accept) begin
          key_d = key_of(in_word_i);
          lvl_d = in_word_i.level;
          idx_d = '0;
          lim_d = cnt_sel;
          if (in_word_i.action == ACT_REGISTER) begin
            if (ok && (cnt_sel < depth_of(in_word_i.level))) begin
              wr_en_o = 1'b1;
              res_d   = '{status: ST_OK, slot: slot_out(SLOT_W'(cnt_sel)),
                          forked_frame: frame_out(new_fork),
                          original_frame: frame_out(new_orig)};
              case (in_word_i.level)
                LEVEL_UPPER:  cnt_d[0] = cnt_sel + CNT_W'(1);
                LEVEL_MIDDLE: cnt_d[1] = cnt_sel + CNT_W'(1);
                LEVEL_LOWER:  cnt_d[2] = cnt_sel + CNT_W'(1);
                default:      cnt_d = cnt_q;
              endcase
            end else begin
              res_d = '{status: ST_FULL, default: '0};
            end
          end else begin
            res_d = '{status: ST_MISS, default: '0};
          end
        end
      end
      FSM_SCAN: begin
        if (idx_q < lim_q) begin
          rd_en_o = 1'b1;
          idx_d   = idx_q + CNT_W'(1);
          pend_d  = !hit;
          cmp_d   = SLOT_W'(idx_q);
        end
        if (hit) begin
          res_d = '{status: ST_OK, slot: slot_out(cmp_q),
                    forked_frame: frame_out(rd_pair_i[PAIR_W-1:FRAME_BITS]),
                    original_frame: frame_out(rd_pair_i[FRAME_BITS-1:0])};
        end
      end
      default: ;
    endcase

    if (!out_valid_q || !out_stall_i) begin
      out_valid_d = load;
      if (load) begin
        out_d = res_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FSM_IDLE;
      cnt_q       <= '{default: '0};
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    lvl_q <= lvl_d;
    idx_q <= idx_d;
    lim_q <= lim_d;
    cmp_q <= cmp_d;
    res_q <= res_d;
    out_q <= out_d;
  end

  assign in_stall_o  = (state_q != FSM_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

>>> rtl/core/forked_page_table_registry.sv
// Top level of the forked page-table registry: sequencer plus key and frame stores.
// Depends on fptr_pkg, fptr_mem and fptr_ctrl.
//
// The input channel (in_valid_i, in_stall_o, in_word_i) takes one word per item:
// a lookup or a register request for the PDPT, PD or PT table. The output channel
// (out_valid_o, out_stall_i, out_word_o) returns exactly one result word per item.
// The three tables share one key memory and one frame memory, each with a
// registered read; a lookup reads one slot per cycle.
// A register item writes both memories as it is accepted, if its table has room;
// its result then goes to the output register. A lookup compares the slots of its
// table in order until the key matches or the last filled slot has been compared;
// a lookup of an empty table or of an invalid level goes straight to the done state.
// The block takes one item at a time; the output register lets the next item be
// accepted while a finished result still waits for the receiver.
// Reset empties all tables at once by clearing their fill counts; no memory sweep
// is needed. While the receiver stalls, the result word holds and a finished
// second result waits in the sequencer with in_stall_o high.
module forked_page_table_registry import fptr_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_word_t  in_word_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_word_t out_word_o
);

  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [KEY_W-1:0]  wr_key;
  logic [PAIR_W-1:0] wr_pair;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [KEY_W-1:0]  rd_key;
  logic [PAIR_W-1:0] rd_pair;

  fptr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_word_o (out_word_o),
    .wr_en_o    (wr_en),
    .wr_addr_o  (wr_addr),
    .wr_key_o   (wr_key),
    .wr_pair_o  (wr_pair),
    .rd_en_o    (rd_en),
    .rd_addr_o  (rd_addr),
    .rd_key_i   (rd_key),
    .rd_pair_i  (rd_pair)
  );

  fptr_mem #(
    .WIDTH(KEY_W),
    .DEPTH(TOTAL_DEPTH)
  ) u_key_mem (
    .clk_i    (clk_i),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_key),
    .rd_en_i  (rd_en),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_key)
  );

  fptr_mem #(
    .WIDTH(PAIR_W),
    .DEPTH(TOTAL_DEPTH)
  ) u_frame_mem (
    .clk_i    (clk_i),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_pair),
    .rd_en_i  (rd_en),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_pair)
  );

endmodule
